@@ sv/bcd_rtc_check_and_time_offset_unit_defines.svh @@
// assertion macros shared by the rtc check rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef BCD_RTC_CHECK_AND_TIME_OFFSET_UNIT_DEFINES_SVH
`define BCD_RTC_CHECK_AND_TIME_OFFSET_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on clk_i outside reset
`define BCDRTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i outside reset
`define BCDRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`else

`define BCDRTC_ASSERT_IMP(lbl, ante, cons, msg)
`define BCDRTC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/bcdrtc_pkg.sv @@
// types, constants and helper functions of the rtc check unit
// no dependencies
package bcdrtc_pkg;

  // bcd conversion
  localparam logic [7:0] BcdBad   = 8'hFF;
  localparam logic [7:0] BcdLimit = 8'hA0;
  localparam logic [3:0] DigitMax = 4'd9;

  // calendar and time limits
  localparam logic [15:0] DaysPerYear = 16'd365;
  localparam logic [7:0]  MonthsMax   = 8'd12;
  localparam logic [7:0]  FebMonth    = 8'd2;
  localparam logic [7:0]  HourMax     = 8'd24;
  localparam logic [7:0]  MinSecMax   = 8'd60;
  localparam logic [7:0]  SecPerMin   = 8'd60;
  localparam logic [7:0]  MinPerHour  = 8'd60;
  localparam logic [7:0]  HoursPerDay = 8'd24;

  // error flag bit positions
  localparam int unsigned FlagPower  = 0;
  localparam int unsigned Flag12h    = 1;
  localparam int unsigned FlagYear   = 2;
  localparam int unsigned FlagMonth  = 3;
  localparam int unsigned FlagDay    = 4;
  localparam int unsigned FlagHour   = 5;
  localparam int unsigned FlagMinute = 6;
  localparam int unsigned FlagSecond = 7;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_OFFSET_DAYS    = 2'd0,
    CFG_OFFSET_HOURS   = 2'd1,
    CFG_OFFSET_MINUTES = 2'd2,
    CFG_OFFSET_SECONDS = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgWidth = 16;

  // input beat
  typedef struct packed {
    logic [7:0] bcd_year;
    logic [7:0] bcd_month;
    logic [7:0] bcd_day;
    logic [7:0] bcd_hour;
    logic [7:0] bcd_minute;
    logic [7:0] bcd_second;
    logic       power_lost;
    logic       mode_24h;
  } item_t;

  // result beat
  typedef struct packed {
    logic [7:0]         error_flags;
    logic [15:0]        day_count;
    logic signed [15:0] diff_days;
    logic signed [7:0]  diff_hours;
    logic signed [7:0]  diff_minutes;
    logic signed [7:0]  diff_seconds;
  } result_t;

  // date check status between the date unit and the top level
  typedef struct packed {
    logic        year_bad;
    logic        month_bad;
    logic        day_bad;
    logic [15:0] day_count;
  } date_t;

  // bcd byte to binary, invalid digits give BcdBad
  function automatic logic [7:0] bcd_to_bin(logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    if (b >= BcdLimit || b[3:0] > DigitMax) begin
      return BcdBad;
    end
    return 8'((tens << 3) + (tens << 1) + {4'd0, b[3:0]});
  endfunction

  // days in a month of a common year
  function automatic logic [4:0] month_len(logic [3:0] m);
    case (m)
      4'd2:                      return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  // days of a common year before the first of a month
  function automatic logic [8:0] month_start(logic [3:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

@@ sv/bcdrtc_date.sv @@
// date check and day count of one bcd reading, combinational
// depends on bcdrtc_pkg
module bcdrtc_date (
  input  logic [7:0]         bcd_year_i,
  input  logic [7:0]         bcd_month_i,
  input  logic [7:0]         bcd_day_i,
  output bcdrtc_pkg::date_t  date_o
);
  import bcdrtc_pkg::*;

  logic [7:0]  year, month, day;
  logic        year_bad, month_bad, day_bcd_bad, date_ok, leap;
  logic [5:0]  day_lim;
  logic [6:0]  yr_m1;
  logic [15:0] year_days, count;

  // digit conversion
  assign year  = bcd_to_bin(bcd_year_i);
  assign month = bcd_to_bin(bcd_month_i);
  assign day   = bcd_to_bin(bcd_day_i);

  assign year_bad    = (year == BcdBad);
  assign month_bad   = (month == BcdBad) || (month == 8'd0) || (month > MonthsMax);
  assign day_bcd_bad = (day == BcdBad);
  assign date_ok     = !year_bad && !month_bad && !day_bcd_bad;

  // valid years are 0..99, where a leap year is a multiple of four
  assign leap = (year[1:0] == 2'b00);

  // month length, february gets one more in a leap year
  assign day_lim = {1'b0, month_len(month[3:0])} +
                   6'((month == FebMonth) && leap);

  // whole years from year 1 up to the one before; leap years among them
  assign yr_m1     = year[6:0] - 7'd1;
  assign year_days = (year == 8'd0) ? 16'd0
                   : 16'(16'(yr_m1) * DaysPerYear) + 16'(yr_m1 >> 2);

  // year part, month part, leap day, day of month
  assign count = year_days + 16'(month_start(month[3:0])) +
                 16'((month > FebMonth) && leap) + 16'(day);

  assign date_o.year_bad  = year_bad;
  assign date_o.month_bad = month_bad;
  assign date_o.day_bad   = day_bcd_bad || (date_ok && (day > {2'b00, day_lim}));
  assign date_o.day_count = date_ok ? count : 16'd0;

endmodule

@@ sv/bcd_rtc_check_and_time_offset_unit.sv @@
// top level of the bcd rtc reading check and time offset unit
// depends on bcdrtc_pkg, bcdrtc_date and the assertion macro header
//
// Takes one rtc reading per clock: a beat is accepted whenever start_i is
// high (busy_o stays low, the unit never refuses a beat). Each result comes
// out on result_o with done_o high for exactly one cycle; there is no
// way to hold it, so the receiver must take it then. A reading passes
// through the input register and the result register, with the bcd
// decode, calendar check, day count and borrow chain between them. The
// offset registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
// should only change while no reading is in flight.
`include "bcd_rtc_check_and_time_offset_unit_defines.svh"

module bcd_rtc_check_and_time_offset_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  bcdrtc_pkg::item_t                        item_i,
  output logic                                     busy_o,
  output logic                                     done_o,
  output bcdrtc_pkg::result_t                      result_o,
  input  logic                                     cfg_we_i,
  input  bcdrtc_pkg::cfg_idx_e                     cfg_idx_i,
  input  logic [bcdrtc_pkg::CfgWidth-1:0]          cfg_wdata_i
);
  import bcdrtc_pkg::*;

  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        done_q;
  result_t     result_q, result_d;
  logic [15:0] off_days_q;
  logic [7:0]  off_hours_q, off_minutes_q, off_seconds_q;

  date_t       date;
  logic [7:0]  hour, minute, second;
  logic [7:0]  s_diff, m_diff, h_diff;
  logic [15:0] d_diff;
  logic [7:0]  flags;

  assign busy_o = 1'b0;

  // offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_days_q    <= '0;
      off_hours_q   <= '0;
      off_minutes_q <= '0;
      off_seconds_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_DAYS:    off_days_q    <= cfg_wdata_i;
        CFG_OFFSET_HOURS:   off_hours_q   <= cfg_wdata_i[7:0];
        CFG_OFFSET_MINUTES: off_minutes_q <= cfg_wdata_i[7:0];
        CFG_OFFSET_SECONDS: off_seconds_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_item_q <= item_i;
    end
  end

  // calendar part
  bcdrtc_date u_date (
    .bcd_year_i  (s1_item_q.bcd_year),
    .bcd_month_i (s1_item_q.bcd_month),
    .bcd_day_i   (s1_item_q.bcd_day),
    .date_o      (date)
  );

  // time digits
  assign hour   = bcd_to_bin(s1_item_q.bcd_hour);
  assign minute = bcd_to_bin(s1_item_q.bcd_minute);
  assign second = bcd_to_bin(s1_item_q.bcd_second);

  // flag word
  always_comb begin
    flags             = '0;
    flags[FlagPower]  = s1_item_q.power_lost;
    flags[Flag12h]    = !s1_item_q.mode_24h;
    flags[FlagYear]   = date.year_bad;
    flags[FlagMonth]  = date.month_bad;
    flags[FlagDay]    = date.day_bad;
    flags[FlagHour]   = (hour == BcdBad) || (hour > HourMax);
    flags[FlagMinute] = (minute == BcdBad) || (minute > MinSecMax);
    flags[FlagSecond] = (second == BcdBad) || (second > MinSecMax);
  end

  // offset subtraction with borrow from seconds up to days
  always_comb begin
    s_diff = second - off_seconds_q;
    m_diff = minute - off_minutes_q;
    h_diff = hour - off_hours_q;
    d_diff = date.day_count - off_days_q;
    if (s_diff[7]) begin
      s_diff = s_diff + SecPerMin;
      m_diff = m_diff - 8'd1;
    end
    if (m_diff[7]) begin
      m_diff = m_diff + MinPerHour;
      h_diff = h_diff - 8'd1;
    end
    if (h_diff[7]) begin
      h_diff = h_diff + HoursPerDay;
      d_diff = d_diff - 16'd1;
    end
    result_d.error_flags  = flags;
    result_d.day_count    = date.day_count;
    result_d.diff_days    = d_diff;
    result_d.diff_hours   = h_diff;
    result_d.diff_minutes = m_diff;
    result_d.diff_seconds = s_diff;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // checks
  `BCDRTC_ASSERT_NEXT(a_latency, start_i && !busy_o, ##1 done_o, "accepted beat gave no result")
  `BCDRTC_ASSERT_IMP(a_done_src, done_o, $past(s1_valid_q), "result without a staged beat")
  `BCDRTC_ASSERT_IMP(a_bad_date_zero,
      done_o && (result_o.error_flags[FlagYear] || result_o.error_flags[FlagMonth]),
      result_o.day_count == 16'd0, "day count set for an invalid date")

endmodule
